@@ sv/btha_pkg.sv @@
`default_nettype none

package btha_pkg;

    localparam int BLOCK_BYTES   = 4096;
    localparam int TABLE_ENTRIES = 1024;
    localparam int ADDRESS_BITS  = 32;

    localparam int DATA_W      = 32;
    localparam int COUNT_FLD_W = 11;
    localparam int PADDR_W     = 3;
    localparam int ENTRY_W     = 3;

    localparam int IDX_W       = $clog2(TABLE_ENTRIES);
    localparam int CNT_W       = $clog2(TABLE_ENTRIES + 1);
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int NEED_W      = DATA_W - BLOCK_SHIFT + 1;

    localparam logic [ENTRY_W-1:0] FLAG_USED  = 3'h1;
    localparam logic [ENTRY_W-1:0] FLAG_FIRST = 3'h2;
    localparam logic [ENTRY_W-1:0] FLAG_NEXT  = 3'h4;
    localparam logic [ENTRY_W-1:0] ENTRY_FREE = 3'h0;
    localparam int                 NEXT_BIT   = 2;

    localparam logic [DATA_W-1:0]      HEAP_BASE_RST   = 32'h0;
    localparam logic [COUNT_FLD_W-1:0] BLOCK_COUNT_RST = 11'd1024;

    typedef enum logic {
        CMD_ALLOC,
        CMD_FREE
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_DONE,
        STATUS_NOMEM,
        STATUS_RANGE
    } status_t;

    typedef enum logic {
        REG_HEAP_BASE,
        REG_BLOCK_COUNT
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MARK,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic              command;
        logic [DATA_W-1:0] size_bytes;
        logic [DATA_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] alloc_address;
        status_t           status;
    } res_t;

endpackage

`default_nettype wire

@@ sv/block_table_heap_allocator_core.sv @@
`default_nettype none

// First-fit block allocator over a 1024-entry block table held in one
// synchronous RAM. After reset the table is swept clear with in_ready
// low; configuration writes are taken meanwhile. An allocate is decoded,
// then the table is scanned entry by entry until a free run of the needed
// length is found, then the blocks of the run are marked one by one, then
// the result state hands the word to the output register. A free is
// decoded, walks the has-next chain clearing each entry along it, and ends
// in the result state. Requests that fail the size or range check go from
// decode straight to the result state. The single read port of the table
// sets the scan at one entry per cycle.
module block_table_heap_allocator_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             command,
    input  wire logic [btha_pkg::DATA_W-1:0]      size_bytes,
    input  wire logic [btha_pkg::DATA_W-1:0]      address,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  ok,
    output logic [btha_pkg::DATA_W-1:0]           alloc_address,
    output logic [1:0]                            status,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [btha_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [btha_pkg::DATA_W-1:0]      pwdata,
    output logic [btha_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);

    logic [btha_pkg::DATA_W-1:0]      heap_base_reg, heap_base_next;
    logic [btha_pkg::COUNT_FLD_W-1:0] block_count_reg, block_count_next;
    logic                             out_valid_reg, out_valid_next;
    btha_pkg::res_t                   out_res_reg, out_res_next;

    btha_pkg::req_t                   req;
    btha_pkg::res_t                   res;
    logic                             res_valid;
    logic                             res_ready;
    logic                             cfg_wr;
    btha_pkg::reg_idx_t               cfg_idx;

    assign req = '{command: command, size_bytes: size_bytes, address: address};

    btha_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req         (req),
        .heap_base   (heap_base_reg),
        .block_count (block_count_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = btha_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        heap_base_next   = heap_base_reg;
        block_count_next = block_count_reg;
        prdata           = '0;
        case (cfg_idx)
            btha_pkg::REG_HEAP_BASE:
            begin
                prdata = heap_base_reg;
                if (cfg_wr)
                begin
                    heap_base_next = pwdata;
                end
            end
            btha_pkg::REG_BLOCK_COUNT:
            begin
                prdata = btha_pkg::DATA_W'(block_count_reg);
                if (cfg_wr)
                begin
                    block_count_next = pwdata[btha_pkg::COUNT_FLD_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // hold the word until taken; refill in the same cycle it leaves
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (res_valid && res_ready)
        begin
            out_res_next   = res;
            out_valid_next = 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ok            = out_res_reg.ok;
    assign alloc_address = out_res_reg.alloc_address;
    assign status        = out_res_reg.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg   <= btha_pkg::HEAP_BASE_RST;
            block_count_reg <= btha_pkg::BLOCK_COUNT_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            heap_base_reg   <= heap_base_next;
            block_count_reg <= block_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

endmodule

`default_nettype wire

@@ sv/btha_ram.sv @@
`default_nettype none

module btha_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 3
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/btha_engine.sv @@
`default_nettype none

module btha_engine (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire btha_pkg::req_t                   req,
    input  wire logic [btha_pkg::DATA_W-1:0]      heap_base,
    input  wire logic [btha_pkg::COUNT_FLD_W-1:0] block_count,
    output logic                                  res_valid,
    input  wire logic                             res_ready,
    output btha_pkg::res_t                        res
);

    localparam int IDX_W  = btha_pkg::IDX_W;
    localparam int CNT_W  = btha_pkg::CNT_W;
    localparam int NEED_W = btha_pkg::NEED_W;
    localparam int DW     = btha_pkg::DATA_W;
    localparam int AB     = btha_pkg::ADDRESS_BITS;
    localparam int EW     = btha_pkg::ENTRY_W;

    btha_pkg::state_t         state_reg, state_next;
    btha_pkg::cmd_t           cmd_reg, cmd_next;
    logic [DW-1:0]            size_reg, size_next;
    logic [DW-1:0]            addr_reg, addr_next;
    logic [CNT_W-1:0]         need_reg, need_next;
    logic [CNT_W-1:0]         run_reg, run_next;
    logic [IDX_W-1:0]         start_reg, start_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]         chk_idx_reg, chk_idx_next;
    logic                     chk_valid_reg, chk_valid_next;
    btha_pkg::res_t           rslt_reg, rslt_next;

    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic [EW-1:0]            mem_wdata;
    logic [EW-1:0]            mem_rdata;

    logic [CNT_W-1:0]         count;
    logic [NEED_W-1:0]        need_full;
    logic                     alloc_fail;
    logic [DW-1:0]            diff;
    logic [DW-1:0]            idx_full;
    logic                     free_fail;
    logic                     chk_last;
    logic                     cell_free;
    logic [CNT_W-1:0]         run_inc;
    logic                     hit;
    logic                     miss;
    logic                     free_end;
    logic                     mark_last;
    logic [AB-1:0]            base_sum;
    logic [EW-1:0]            mark_flags;

    btha_ram #(
        .DEPTH (btha_pkg::TABLE_ENTRIES),
        .WIDTH (EW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_idx_reg),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        count = (32'(block_count) > 32'(btha_pkg::TABLE_ENTRIES))
              ? CNT_W'(btha_pkg::TABLE_ENTRIES) : CNT_W'(block_count);
        need_full  = NEED_W'(size_reg / btha_pkg::BLOCK_BYTES)
                   + NEED_W'((size_reg % btha_pkg::BLOCK_BYTES) != '0);
        alloc_fail = (need_full == '0) || (32'(need_full) > 32'(count));
        diff       = addr_reg - heap_base;
        idx_full   = diff / btha_pkg::BLOCK_BYTES;
        free_fail  = (addr_reg < heap_base) || (idx_full >= 32'(count));
        chk_last   = (CNT_W'(chk_idx_reg) + CNT_W'(1)) == count;
        cell_free  = mem_rdata == btha_pkg::ENTRY_FREE;
        run_inc    = run_reg + CNT_W'(1);
        hit        = chk_valid_reg && (cmd_reg == btha_pkg::CMD_ALLOC)
                   && cell_free && (run_inc == need_reg);
        miss       = chk_valid_reg && (cmd_reg == btha_pkg::CMD_ALLOC) && !hit && chk_last;
        free_end   = chk_valid_reg && (cmd_reg == btha_pkg::CMD_FREE)
                   && (!mem_rdata[btha_pkg::NEXT_BIT] || chk_last);
        mark_last  = run_inc == need_reg;
        base_sum   = AB'(heap_base) + (AB'(start_reg) << btha_pkg::BLOCK_SHIFT);
        mark_flags = btha_pkg::FLAG_USED
                   | ((run_reg == '0) ? btha_pkg::FLAG_FIRST : btha_pkg::ENTRY_FREE)
                   | (mark_last ? btha_pkg::ENTRY_FREE : btha_pkg::FLAG_NEXT);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btha_pkg::S_CLEAR:
            begin
                if (rd_idx_reg == IDX_W'(btha_pkg::TABLE_ENTRIES - 1))
                begin
                    state_next = btha_pkg::S_IDLE;
                end
            end
            btha_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = btha_pkg::S_CHECK;
                end
            end
            btha_pkg::S_CHECK:
            begin
                if ((cmd_reg == btha_pkg::CMD_ALLOC) ? alloc_fail : free_fail)
                begin
                    state_next = btha_pkg::S_RESULT;
                end
                else
                begin
                    state_next = btha_pkg::S_SCAN;
                end
            end
            btha_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    state_next = btha_pkg::S_MARK;
                end
                else if (miss || free_end)
                begin
                    state_next = btha_pkg::S_RESULT;
                end
            end
            btha_pkg::S_MARK:
            begin
                if (mark_last)
                begin
                    state_next = btha_pkg::S_RESULT;
                end
            end
            btha_pkg::S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = btha_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = btha_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        need_next      = need_reg;
        run_next       = run_reg;
        start_next     = start_reg;
        rd_idx_next    = rd_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = chk_valid_reg;
        rslt_next      = rslt_reg;
        mem_we         = 1'b0;
        mem_waddr      = rd_idx_reg;
        mem_wdata      = btha_pkg::ENTRY_FREE;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        case (state_reg)
            btha_pkg::S_CLEAR:
            begin
                mem_we      = 1'b1;
                rd_idx_next = rd_idx_reg + IDX_W'(1);
            end
            btha_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd_next  = btha_pkg::cmd_t'(req.command);
                size_next = req.size_bytes;
                addr_next = req.address;
            end
            btha_pkg::S_CHECK:
            begin
                chk_valid_next = 1'b0;
                run_next       = '0;
                need_next      = CNT_W'(need_full);
                if (cmd_reg == btha_pkg::CMD_ALLOC)
                begin
                    rd_idx_next = '0;
                    rslt_next   = '{ok: 1'b0, alloc_address: '0, status: btha_pkg::STATUS_NOMEM};
                end
                else
                begin
                    rd_idx_next = IDX_W'(idx_full);
                    rslt_next   = '{ok: 1'b0, alloc_address: '0, status: btha_pkg::STATUS_RANGE};
                end
            end
            btha_pkg::S_SCAN:
            begin
                rd_idx_next    = rd_idx_reg + IDX_W'(1);
                chk_idx_next   = rd_idx_reg;
                chk_valid_next = 1'b1;
                if (chk_valid_reg)
                begin
                    if (cmd_reg == btha_pkg::CMD_ALLOC)
                    begin
                        if (cell_free)
                        begin
                            if (run_reg == '0)
                            begin
                                start_next = chk_idx_reg;
                            end
                            run_next = run_inc;
                        end
                        else
                        begin
                            run_next = '0;
                        end
                        if (hit)
                        begin
                            rd_idx_next = (run_reg == '0) ? chk_idx_reg : start_reg;
                            run_next    = '0;
                        end
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = chk_idx_reg;
                        if (free_end)
                        begin
                            rslt_next = '{ok: 1'b1, alloc_address: '0,
                                          status: btha_pkg::STATUS_DONE};
                        end
                    end
                end
            end
            btha_pkg::S_MARK:
            begin
                mem_we      = 1'b1;
                mem_wdata   = mark_flags;
                rd_idx_next = rd_idx_reg + IDX_W'(1);
                run_next    = run_inc;
                if (mark_last)
                begin
                    rslt_next = '{ok: 1'b1, alloc_address: DW'(base_sum),
                                  status: btha_pkg::STATUS_DONE};
                end
            end
            btha_pkg::S_RESULT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign res = rslt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= btha_pkg::S_CLEAR;
            rd_idx_reg    <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        size_reg    <= size_next;
        addr_reg    <= addr_next;
        need_reg    <= need_next;
        run_reg     <= run_next;
        start_reg   <= start_next;
        chk_idx_reg <= chk_idx_next;
        rslt_reg    <= rslt_next;
    end

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == btha_pkg::S_CLEAR || state_reg == btha_pkg::S_SCAN
                    || state_reg == btha_pkg::S_MARK))
        else $error("table written outside clear, free walk or mark");

    a_run_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == btha_pkg::S_MARK)
        |-> (32'(start_reg) + 32'(need_reg) <= 32'(count)))
        else $error("marked run leaves the table");

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && rslt_reg.status != btha_pkg::STATUS_DONE)
        |-> (!rslt_reg.ok && rslt_reg.alloc_address == '0))
        else $error("failed request carries ok or an address");

    a_hit_to_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == btha_pkg::S_SCAN && hit) |=> (state_reg == btha_pkg::S_MARK
                                                     && run_reg == '0))
        else $error("found run not followed by marking");

endmodule

`default_nettype wire

@@ tb/tb_block_table_heap_allocator_core.sv @@
typedef struct packed {
    int unsigned start;
    int unsigned blocks;
} run_t;

class heap_scoreboard;
    logic [btha_pkg::ENTRY_W-1:0]     block_flags [btha_pkg::TABLE_ENTRIES];
    logic [btha_pkg::DATA_W-1:0]      base_addr;
    logic [btha_pkg::COUNT_FLD_W-1:0] count_reg;
    btha_pkg::res_t                   expected_replies [$];
    run_t                             live_runs [$];
    int unsigned mismatches;
    int unsigned replies_checked;
    int unsigned requests_seen;
    int unsigned runs_placed;
    int unsigned nomem_seen;
    int unsigned frees_done;
    int unsigned range_seen;

    function new();
        foreach (block_flags[i])
            block_flags[i] = btha_pkg::ENTRY_FREE;
        base_addr       = btha_pkg::HEAP_BASE_RST;
        count_reg       = btha_pkg::BLOCK_COUNT_RST;
        mismatches      = 0;
        replies_checked = 0;
        requests_seen   = 0;
        runs_placed     = 0;
        nomem_seen      = 0;
        frees_done      = 0;
        range_seen      = 0;
    endfunction

    function int unsigned active_blocks();
        return (count_reg < btha_pkg::TABLE_ENTRIES) ? count_reg : btha_pkg::TABLE_ENTRIES;
    endfunction

    function void set_register(btha_pkg::reg_idx_t idx, logic [31:0] value);
        case (idx)
            btha_pkg::REG_HEAP_BASE:   base_addr = value;
            btha_pkg::REG_BLOCK_COUNT: count_reg = value[btha_pkg::COUNT_FLD_W-1:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] register_value(btha_pkg::reg_idx_t idx);
        if (idx == btha_pkg::REG_HEAP_BASE)
            return base_addr;
        return 32'(count_reg);
    endfunction

    function void flag_mismatch(string note);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", note);
    endfunction

    function void note_request(btha_pkg::cmd_t cmd, logic [31:0] size, logic [31:0] addr);
        btha_pkg::res_t  reply;
        longint unsigned need;
        longint unsigned run_len;
        longint unsigned first;
        longint unsigned idx;
        longint unsigned n;
        logic [63:0]     sum;
        logic [btha_pkg::ENTRY_W-1:0] e;
        bit              found;
        run_t            kept [$];

        reply.ok            = 1'b0;
        reply.alloc_address = '0;
        n = active_blocks();
        requests_seen++;
        if (cmd == btha_pkg::CMD_ALLOC) begin
            reply.status = btha_pkg::STATUS_NOMEM;
            need = size / btha_pkg::BLOCK_BYTES + ((size % btha_pkg::BLOCK_BYTES) != 0);
            if (need != 0 && need <= n) begin
                run_len = 0;
                first   = 0;
                found   = 1'b0;
                for (longint unsigned i = 0; i < n && !found; i++) begin
                    if (block_flags[i] == btha_pkg::ENTRY_FREE) begin
                        if (run_len == 0)
                            first = i;
                        run_len++;
                        if (run_len == need)
                            found = 1'b1;
                    end else begin
                        run_len = 0;
                    end
                end
                if (found) begin
                    for (longint unsigned i = 0; i < need; i++) begin
                        e = btha_pkg::FLAG_USED;
                        if (i == 0)
                            e = e | btha_pkg::FLAG_FIRST;
                        if (i + 1 < need)
                            e = e | btha_pkg::FLAG_NEXT;
                        block_flags[first + i] = e;
                    end
                    sum = {32'd0, base_addr} + first * btha_pkg::BLOCK_BYTES;
                    if (btha_pkg::ADDRESS_BITS < 64)
                        sum = sum & ((64'd1 << btha_pkg::ADDRESS_BITS) - 64'd1);
                    reply.ok            = 1'b1;
                    reply.alloc_address = sum[31:0];
                    reply.status        = btha_pkg::STATUS_DONE;
                    live_runs.push_back('{start: int'(first), blocks: int'(need)});
                    runs_placed++;
                end
            end
            if (!reply.ok)
                nomem_seen++;
        end else begin
            reply.status = btha_pkg::STATUS_RANGE;
            if (addr >= base_addr) begin
                idx = (addr - base_addr) / btha_pkg::BLOCK_BYTES;
                if (idx < n) begin
                    for (; idx < n; idx++) begin
                        e = block_flags[idx];
                        block_flags[idx] = btha_pkg::ENTRY_FREE;
                        if (!e[btha_pkg::NEXT_BIT])
                            break;
                    end
                    reply.ok     = 1'b1;
                    reply.status = btha_pkg::STATUS_DONE;
                    foreach (live_runs[k])
                        if (block_flags[live_runs[k].start] != btha_pkg::ENTRY_FREE)
                            kept.push_back(live_runs[k]);
                    live_runs = kept;
                    frees_done++;
                end
            end
            if (!reply.ok)
                range_seen++;
        end
        expected_replies.push_back(reply);
    endfunction

    function void check_reply(logic ok_bit, logic [31:0] addr_word, logic [1:0] status_code);
        btha_pkg::res_t want;

        replies_checked++;
        if (expected_replies.size() == 0) begin
            flag_mismatch($sformatf("reply %0d with nothing pending: ok %0b addr %08h status %0d",
                replies_checked, ok_bit, addr_word, status_code));
            return;
        end
        want = expected_replies.pop_front();
        if (ok_bit !== want.ok || addr_word !== want.alloc_address ||
            status_code !== want.status)
            flag_mismatch($sformatf(
                "reply %0d: exp ok %0b addr %08h status %0d, got ok %0b addr %08h status %0d",
                replies_checked, want.ok, want.alloc_address, want.status,
                ok_bit, addr_word, status_code));
    endfunction
endclass

module tb_block_table_heap_allocator_core;

    localparam int AW             = btha_pkg::PADDR_W;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [31:0] size_bytes;
    logic [31:0] address;
    logic        out_valid;
    logic        out_ready;
    logic        ok;
    logic [31:0] alloc_address;
    logic [1:0]  status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic        gaps_on;
    logic        hold_req;
    int unsigned settings_done;
    int unsigned holds_done;

    heap_scoreboard sb = new();

    block_table_heap_allocator_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .size_bytes    (size_bytes),
        .address       (address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ok            (ok),
        .alloc_address (alloc_address),
        .status        (status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_reply(ok, alloc_address, status);
    end

    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left != 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = !(gaps_on && $urandom_range(0, 99) < 26);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || psel || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_request(btha_pkg::cmd_t cmd, logic [31:0] size, logic [31:0] addr);
        while (gaps_on && $urandom_range(0, 99) < 26)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        command    = cmd;
        size_bytes = size;
        address    = addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(cmd, size, addr);
        @(negedge clk);
    endtask

    task automatic write_register(btha_pkg::reg_idx_t idx, logic [31:0] value);
        logic [31:0] readback;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = AW'(4 * int'(idx));
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        sb.set_register(idx, value);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== sb.register_value(idx))
            sb.flag_mismatch($sformatf("register %0d readback: exp %08h got %08h",
                int'(idx), sb.register_value(idx), readback));
    endtask

    task automatic run_mix(int unsigned n, bit with_hold);
        btha_pkg::cmd_t cmd;
        int unsigned    pick;
        int unsigned    sel;
        int unsigned    cnt;
        int unsigned    lim;
        int unsigned    blocks;
        logic [31:0]    base;
        logic [31:0]    size;
        logic [31:0]    addr;
        run_t           r;
        bit             have_live;

        cnt  = sb.active_blocks();
        base = sb.base_addr;
        lim  = (cnt < 8) ? cnt : 8;
        if (lim == 0)
            lim = 1;
        for (int unsigned k = 0; k < n; k++)
        begin
            if (with_hold && k == n / 2)
                hold_req = 1'b1;
            have_live = sb.live_runs.size() != 0;
            pick = $urandom_range(0, 99);
            sel  = $urandom_range(0, 99);
            size = $urandom();
            addr = $urandom();
            if (have_live)
                r = sb.live_runs[$urandom_range(0, sb.live_runs.size() - 1)];
            if (pick < (have_live ? 50 : 80))
            begin
                cmd = btha_pkg::CMD_ALLOC;
                if (sel < 70)
                begin
                    blocks = $urandom_range(1, lim);
                    size   = blocks * btha_pkg::BLOCK_BYTES
                             - $urandom_range(0, btha_pkg::BLOCK_BYTES - 1);
                end
                else if (sel < 78)
                    size = 32'd0;
                else if (sel < 84)
                    size = cnt * btha_pkg::BLOCK_BYTES;
                else if (sel < 88)
                    size = cnt * btha_pkg::BLOCK_BYTES + 1;
                else if (sel < 93)
                    size = $urandom_range(1, (cnt > 0) ? cnt : 1) * btha_pkg::BLOCK_BYTES;
            end
            else
            begin
                cmd = btha_pkg::CMD_FREE;
                if (have_live && sel < 65)
                    addr = base + r.start * btha_pkg::BLOCK_BYTES
                           + ((sel < 50) ? 0 : $urandom_range(0, btha_pkg::BLOCK_BYTES - 1));
                else if (have_live && sel < 75)
                    addr = base + r.start * btha_pkg::BLOCK_BYTES
                           + $urandom_range(0, r.blocks * btha_pkg::BLOCK_BYTES - 1);
                else if (sel < 85)
                    addr = base + $urandom_range(0, (cnt > 0) ? cnt - 1 : 0)
                           * btha_pkg::BLOCK_BYTES
                           + $urandom_range(0, btha_pkg::BLOCK_BYTES - 1);
                else if (sel < 90 && base != 0)
                    addr = $urandom_range(0, base - 1);
                else if (sel < 95)
                    addr = base + cnt * btha_pkg::BLOCK_BYTES + $urandom_range(0, 1 << 20);
            end
            send_request(cmd, size, addr);
        end
        in_valid = 1'b0;
    endtask

    task automatic release_live();
        run_t snapshot [$];
        snapshot = sb.live_runs;
        foreach (snapshot[k])
            send_request(btha_pkg::CMD_FREE, $urandom(),
                sb.base_addr + snapshot[k].start * btha_pkg::BLOCK_BYTES);
        in_valid = 1'b0;
    endtask

    task automatic run_phase(logic [31:0] base, logic [31:0] count_word, int unsigned n,
                             bit with_hold);
        while (sb.expected_replies.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        write_register(btha_pkg::REG_HEAP_BASE, base);
        write_register(btha_pkg::REG_BLOCK_COUNT, count_word);
        settings_done++;
        run_mix(n, with_hold);
        release_live();
    endtask

    initial
    begin : stimulus
        logic [31:0] hb;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = 1'b0;
        size_bytes    = '0;
        address       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        gaps_on       = 1'b1;
        hold_req      = 1'b0;
        settings_done = 0;
        holds_done    = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_register(btha_pkg::REG_HEAP_BASE, 32'h0010_0000);
        write_register(btha_pkg::REG_BLOCK_COUNT, 32'd1024);
        settings_done++;
        hb = sb.base_addr;
        send_request(btha_pkg::CMD_ALLOC, 32'd0, $urandom());
        send_request(btha_pkg::CMD_ALLOC, 32'd1, $urandom());
        send_request(btha_pkg::CMD_ALLOC, 32'd4096, $urandom());
        send_request(btha_pkg::CMD_ALLOC, 32'd4097, $urandom());
        send_request(btha_pkg::CMD_ALLOC, 32'hFFFF_FFFF, $urandom());
        send_request(btha_pkg::CMD_ALLOC, 32'h0040_0001, $urandom());
        send_request(btha_pkg::CMD_FREE, $urandom(), hb + 32'h0000_1FFF);
        send_request(btha_pkg::CMD_FREE, $urandom(), hb + 32'h0000_3000);
        send_request(btha_pkg::CMD_FREE, $urandom(), hb + 32'h0000_2000);
        send_request(btha_pkg::CMD_FREE, $urandom(), hb + 32'h0000_5000);
        send_request(btha_pkg::CMD_FREE, $urandom(), 32'h0000_0000);
        send_request(btha_pkg::CMD_FREE, $urandom(), hb + 32'h0040_0000);
        send_request(btha_pkg::CMD_FREE, $urandom(), 32'hFFFF_FFFF);
        send_request(btha_pkg::CMD_FREE, $urandom(), hb);
        send_request(btha_pkg::CMD_ALLOC, 32'h0000_3000, $urandom());
        send_request(btha_pkg::CMD_FREE, $urandom(), hb + 32'h0000_1000);
        send_request(btha_pkg::CMD_ALLOC, 32'h0000_1000, $urandom());
        send_request(btha_pkg::CMD_FREE, $urandom(), hb);
        send_request(btha_pkg::CMD_ALLOC, 32'h0040_0000, $urandom());
        send_request(btha_pkg::CMD_ALLOC, 32'd1, $urandom());
        send_request(btha_pkg::CMD_FREE, $urandom(), hb + 32'h003F_F005);
        send_request(btha_pkg::CMD_ALLOC, 32'd1, $urandom());
        send_request(btha_pkg::CMD_FREE, $urandom(), hb);
        send_request(btha_pkg::CMD_ALLOC, 32'hFFFF_F000, $urandom());
        run_mix(100, 1'b1);
        release_live();

        run_phase(32'h8000_0000, 32'd16, 70, 1'b0);
        run_phase(32'hFFFF_C000, 32'd8, 50, 1'b0);
        run_phase(32'h0000_0000, 32'd1, 30, 1'b0);
        run_phase(32'h1234_5000, 32'd0, 20, 1'b0);
        gaps_on = 1'b0;
        run_phase(32'h7FFF_FA5C, 32'hFFFF_FFFF, 100, 1'b0);
        gaps_on = 1'b1;
        run_phase($urandom() & 32'hFFFF_F000, $urandom_range(2, 300), 80, 1'b1);
        run_phase(32'hFFFF_FFFF, 32'd1024, 40, 1'b0);

        while (sb.expected_replies.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        $display("Covered %0d requests over %0d register settings with %0d long output holds:",
            sb.requests_seen, settings_done, holds_done);
        $display("%0d runs placed, %0d out of memory, %0d frees, %0d out of range, %0d mismatches",
            sb.runs_placed, sb.nomem_seen, sb.frees_done, sb.range_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
sv/btha_pkg.sv
sv/btha_ram.sv
sv/btha_engine.sv
sv/block_table_heap_allocator_core.sv
tb/tb_block_table_heap_allocator_core.sv
